FILE: rtl/udiv_pkg.sv
package udiv_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture operands and set up the remainder and quotient
    logic step;   // one restoring shift-and-subtract iteration
  } udiv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic divisor_zero;   // the divisor on the input ports is zero
  } udiv_status_t;

endpackage

FILE: rtl/udiv_datapath.sv
module udiv_datapath
  import udiv_pkg::*;
#(
  parameter int HALF_WIDTH = 64
) (
  input  logic                  clk,
  input  logic [HALF_WIDTH-1:0] num_hi,
  input  logic [HALF_WIDTH-1:0] num_lo,
  input  logic [HALF_WIDTH-1:0] den_hi,
  input  logic [HALF_WIDTH-1:0] den_lo,
  input  udiv_cmd_t             cmd,
  output udiv_status_t          status,
  output logic [HALF_WIDTH-1:0] quot_hi,
  output logic [HALF_WIDTH-1:0] quot_lo,
  output logic [HALF_WIDTH-1:0] rem_hi,
  output logic [HALF_WIDTH-1:0] rem_lo,
  output logic                  divide_by_zero
);

  localparam int W = 2 * HALF_WIDTH;

  logic [W-1:0] rem;
  logic [W-1:0] quo;   // dividend bits leave at the top, quotient bits enter at the bottom
  logic [W-1:0] div;
  logic         dbz;

  logic         zero_in;
  logic [W:0]   rem_shift;
  logic [W:0]   diff;

  assign zero_in = ({den_hi, den_lo} == '0);
  assign status.divisor_zero = zero_in;

  // The shifted remainder is always below twice the divisor, so a non-negative
  // difference always fits back into W bits.
  assign rem_shift = {rem, quo[W-1]};
  assign diff      = rem_shift - {1'b0, div};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div <= {den_hi, den_lo};
      dbz <= zero_in;
      if (zero_in) begin
        rem <= {num_hi, num_lo};
        quo <= '1;
      end else begin
        rem <= '0;
        quo <= {num_hi, num_lo};
      end
    end else if (cmd.step) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quot_hi        = quo[W-1:HALF_WIDTH];
  assign quot_lo        = quo[HALF_WIDTH-1:0];
  assign rem_hi         = rem[W-1:HALF_WIDTH];
  assign rem_lo         = rem[HALF_WIDTH-1:0];
  assign divide_by_zero = dbz;

endmodule

FILE: rtl/udiv_controller.sv
module udiv_controller
  import udiv_pkg::*;
#(
  parameter int HALF_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  udiv_status_t status,
  output udiv_cmd_t    cmd,
  output logic         busy,
  output logic         done
);

  localparam int W  = 2 * HALF_WIDTH;
  localparam int CW = $clog2(W);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          count_next = CW'(W - 1);
          state_next = status.divisor_zero ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (count == '0) begin
          state_next = ST_FINISH;
        end else begin
          count_next = count - 1'b1;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_FINISH);

endmodule

FILE: rtl/unsigned_divide_128.sv
// Unsigned 2*HALF_WIDTH-bit divider (128 bits by default). An item is taken
// at a rising edge where start is high and busy is low; busy then stays high
// until the result has been shown. The quotient and remainder appear on their
// ports for exactly one cycle, marked by done, and the receiver cannot hold
// them off: it must capture them in that cycle, as they are replaced by the
// next item's work. After acceptance the restoring shift-and-subtract loop
// retires one quotient bit per cycle through a single subtractor of
// 2*HALF_WIDTH + 1 bits, and the result is then shown in the done cycle; busy
// stays high through the done cycle, so a new item is taken only once the
// last one is through. A zero divisor skips the loop: done is high in the
// cycle right after acceptance with divide_by_zero set, an all-ones quotient
// and the dividend as the remainder, and the next item can be taken once that
// done cycle is over.
module unsigned_divide_128
  import udiv_pkg::*;
#(
  parameter int HALF_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [HALF_WIDTH-1:0] num_hi,
  input  logic [HALF_WIDTH-1:0] num_lo,
  input  logic [HALF_WIDTH-1:0] den_hi,
  input  logic [HALF_WIDTH-1:0] den_lo,
  output logic                  done,
  output logic [HALF_WIDTH-1:0] quot_hi,
  output logic [HALF_WIDTH-1:0] quot_lo,
  output logic [HALF_WIDTH-1:0] rem_hi,
  output logic [HALF_WIDTH-1:0] rem_lo,
  output logic                  divide_by_zero
);

  udiv_cmd_t    cmd;
  udiv_status_t status;

  // The controller sequences load, the bit iterations and the done cycle.
  udiv_controller #(
    .HALF_WIDTH(HALF_WIDTH)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath holds the operands, the partial remainder and the quotient.
  // Its result registers are only written on load and on iteration, so they
  // stay steady through the done cycle.
  udiv_datapath #(
    .HALF_WIDTH(HALF_WIDTH)
  ) u_dp (
    .clk            (clk),
    .num_hi         (num_hi),
    .num_lo         (num_lo),
    .den_hi         (den_hi),
    .den_lo         (den_lo),
    .cmd            (cmd),
    .status         (status),
    .quot_hi        (quot_hi),
    .quot_lo        (quot_lo),
    .rem_hi         (rem_hi),
    .rem_lo         (rem_lo),
    .divide_by_zero (divide_by_zero)
  );

endmodule

FILE: tb/unsigned_divide_128_test.sv
module unsigned_divide_128_test;

  // The divider is built at its default width: two 64-bit halves per operand.
  localparam int HW = 64;
  localparam int DW = 2 * HW;

  // A divide runs from the accepting edge to the end of the done cycle, and
  // the next item can be taken after that, so DIVIDE_CYCLES is the spacing of
  // items sent back to back. After the last result we wait this long again,
  // plus a margin, so that a stray extra result would still be seen.
  localparam int DIVIDE_CYCLES = DW + 2;
  localparam int RANDOM_ITEMS  = 1000;
  // The closing stretch of the random part runs with no idling at all.
  localparam int QUIET_ITEMS   = 100;

  localparam logic [DW-1:0] ALL_ONES  = '1;
  localparam logic [DW-1:0] HALF_ONES = {{HW{1'b0}}, {HW{1'b1}}};
  localparam logic [DW-1:0] TOP_BIT   = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] HIGH_ONE  = {{(HW-1){1'b0}}, 1'b1, {HW{1'b0}}};
  localparam logic [DW-1:0] PATTERN_A = {(DW/2){2'b10}};
  localparam logic [DW-1:0] PATTERN_5 = {(DW/2){2'b01}};
  localparam logic [DW-1:0] MIXED     = 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;

  // One quotient/remainder pair as the block reports it, held as whole
  // 128-bit values; the checker splits them into halves port by port.
  typedef struct packed {
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
    logic          zero_div;
  } divide_result_t;

  // One row of the directed table. When typed is set the result written in
  // the row is expected; otherwise the long-division model supplies it.
  typedef struct packed {
    logic [DW-1:0]  dividend;
    logic [DW-1:0]  divisor;
    logic           typed;
    divide_result_t result;
  } divide_case_t;

  logic          clk            = 1'b0;
  logic          rst            = 1'b1;
  logic          start          = 1'b0;
  logic [HW-1:0] num_hi         = '0;
  logic [HW-1:0] num_lo         = '0;
  logic [HW-1:0] den_hi         = '0;
  logic [HW-1:0] den_lo         = '0;
  logic          busy;
  logic          done;
  logic [HW-1:0] quot_hi;
  logic [HW-1:0] quot_lo;
  logic [HW-1:0] rem_hi;
  logic [HW-1:0] rem_lo;
  logic          divide_by_zero;

  // Results the block still owes, oldest first.
  divide_result_t pending_results[$];
  divide_case_t   directed_cases[$];
  int             mismatch_count = 0;
  // Idling is switched on and off in stretches so that some runs of items
  // go back to back and others are broken up by gaps.
  bit             idling_enabled = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unsigned_divide_128 #(
    .HALF_WIDTH(HW)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .num_hi        (num_hi),
    .num_lo        (num_lo),
    .den_hi        (den_hi),
    .den_lo        (den_lo),
    .done          (done),
    .quot_hi       (quot_hi),
    .quot_lo       (quot_lo),
    .rem_hi        (rem_hi),
    .rem_lo        (rem_lo),
    .divide_by_zero(divide_by_zero)
  );

  // Restoring long division, one quotient bit per pass from the top down.
  // The partial remainder carries one extra bit so that a divisor above
  // 2^127 is compared correctly after the shift. A zero divisor skips the
  // loop and gives an all-ones quotient with the dividend as remainder.
  function automatic divide_result_t long_divide(input logic [DW-1:0] num,
                                                 input logic [DW-1:0] den);
    divide_result_t res;
    logic [DW:0]    partial;
    int             i;
    res     = '0;
    partial = '0;
    if (den == '0) begin
      res.quotient  = ALL_ONES;
      res.remainder = num;
      res.zero_div  = 1'b1;
      return res;
    end
    for (i = DW - 1; i >= 0; i--) begin
      partial = {partial[DW-1:0], num[i]};
      if (partial >= {1'b0, den}) begin
        partial         = partial - {1'b0, den};
        res.quotient[i] = 1'b1;
      end
    end
    res.remainder = partial[DW-1:0];
    return res;
  endfunction

  function automatic logic [DW-1:0] random_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // A random value whose bit length is itself random, so that quotients of
  // every length come up rather than mostly tiny ones.
  function automatic logic [DW-1:0] random_sized();
    return random_wide() >> $urandom_range(0, DW - 1);
  endfunction

  task automatic add_case(input logic [DW-1:0] num, input logic [DW-1:0] den,
                          input logic typed, input logic [DW-1:0] quo,
                          input logic [DW-1:0] remn, input logic zdiv);
    divide_case_t row;
    row.dividend         = num;
    row.divisor          = den;
    row.typed            = typed;
    row.result.quotient  = quo;
    row.result.remainder = remn;
    row.result.zero_div  = zdiv;
    directed_cases.push_back(row);
  endtask

  // Present one item from the falling edge on and hold it until a rising
  // edge finds busy low. Start stays high afterwards; the next item or an
  // idle gap replaces it at the following falling edge, and since busy is
  // high by then the old operands cannot be taken twice.
  task automatic send_item(input logic [DW-1:0] num, input logic [DW-1:0] den,
                           input divide_result_t expected);
    @(negedge clk);
    start  <= 1'b1;
    num_hi <= num[DW-1:HW];
    num_lo <= num[HW-1:0];
    den_hi <= den[DW-1:HW];
    den_lo <= den[HW-1:0];
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(expected);
  endtask

  // Unless quiet or idling is off, half the time a burst with start low follows;
  // half of those only begin once the block has gone idle, so that the gap is
  // really seen by the block instead of hiding under a divide in progress.
  task automatic maybe_idle(input bit quiet);
    int gap;
    gap = $urandom_range(1, 15);
    if (!quiet && idling_enabled && $urandom_range(0, 1) == 1) begin
      @(negedge clk);
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy !== 1'b0);
      end
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic check_field(input string label, input logic [HW-1:0] want,
                             input logic [HW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // Every done cycle must match the oldest outstanding item, half by half.
  // The result is marked by done for that one cycle only, so it is taken at
  // the rising edge that closes it. An unknown done counts as a result.
  always @(posedge clk) begin : check_results
    divide_result_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding: expected none, actual q=%h_%h r=%h_%h",
                 $time, quot_hi, quot_lo, rem_hi, rem_lo);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("quot_hi",        want.quotient[DW-1:HW],  quot_hi);
        check_field("quot_lo",        want.quotient[HW-1:0],   quot_lo);
        check_field("rem_hi",         want.remainder[DW-1:HW], rem_hi);
        check_field("rem_lo",         want.remainder[HW-1:0],  rem_lo);
        check_field("divide_by_zero", HW'(want.zero_div),      HW'(divide_by_zero));
      end
    end
  end

  initial begin : stimulus
    divide_case_t  row;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    logic [DW-1:0] swap;
    int            kind;
    int            n;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Divide by zero comes first, with an empty, a full and
    // a mixed dividend: the quotient must be all ones and the remainder the
    // dividend itself.
    add_case('0,       '0, 1'b1, ALL_ONES, '0,       1'b1);
    add_case(ALL_ONES, '0, 1'b1, ALL_ONES, ALL_ONES, 1'b1);
    add_case(MIXED,    '0, 1'b1, ALL_ONES, MIXED,    1'b1);
    // Extremes of dividend and divisor.
    add_case('0,       1,        1'b1, '0,       '0, 1'b0);
    add_case(ALL_ONES, 1,        1'b1, ALL_ONES, '0, 1'b0);
    add_case(ALL_ONES, ALL_ONES, 1'b1, 1,        '0, 1'b0);
    add_case('0,       ALL_ONES, 1'b1, '0,       '0, 1'b0);
    add_case(1,        1,        1'b1, 1,        '0, 1'b0);
    // A divisor larger than the dividend leaves the dividend as remainder.
    add_case(5,            7,        1'b1, '0, 5,            1'b0);
    add_case(ALL_ONES - 1, ALL_ONES, 1'b1, '0, ALL_ONES - 1, 1'b0);
    // Borrows across the boundary between the two halves.
    add_case(HIGH_ONE, HALF_ONES,    1'b1, 1,             1,             1'b0);
    add_case(HIGH_ONE, HIGH_ONE,     1'b1, 1,             '0,            1'b0);
    add_case(ALL_ONES, TOP_BIT,      1'b1, 1,             ALL_ONES >> 1, 1'b0);
    add_case(ALL_ONES, 2,            1'b1, ALL_ONES >> 1, 1,             1'b0);
    add_case(ALL_ONES, ALL_ONES - 1, 1'b1, 1,             1,             1'b0);
    // Rows left to the model: alternating patterns, divisors confined to one
    // half or spanning both, and divisors above 2^127 where the remainder overflows on shift.
    add_case(PATTERN_A, PATTERN_5,            1'b0, '0, '0, 1'b0);
    add_case(PATTERN_5, PATTERN_A,            1'b0, '0, '0, 1'b0);
    add_case(ALL_ONES,  HALF_ONES,            1'b0, '0, '0, 1'b0);
    add_case(ALL_ONES,  ~HALF_ONES,           1'b0, '0, '0, 1'b0);
    add_case(ALL_ONES,  HIGH_ONE,             1'b0, '0, '0, 1'b0);
    add_case(MIXED,     HIGH_ONE + 3,         1'b0, '0, '0, 1'b0);
    add_case(MIXED,     3,                    1'b0, '0, '0, 1'b0);
    add_case(HALF_ONES, TOP_BIT >> HW,        1'b0, '0, '0, 1'b0);
    add_case(ALL_ONES,  TOP_BIT | (TOP_BIT >> 1), 1'b0, '0, '0, 1'b0);
    add_case(ALL_ONES ^ (TOP_BIT >> 1), TOP_BIT | 1, 1'b0, '0, '0, 1'b0);

    foreach (directed_cases[i]) begin
      row = directed_cases[i];
      send_item(row.dividend, row.divisor,
                row.typed ? row.result : long_divide(row.dividend, row.divisor));
      maybe_idle(1'b0);
    end

    // Random part. Most items are ordinary divides with operands of random
    // length; a share goes to a zero divisor, a divisor not below the dividend,
    // one within one of it, top-bit divisors and short ones under wide dividends.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0)
        idling_enabled = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      num  = random_sized();
      den  = random_sized();
      if (kind < 5) begin
        den = '0;
      end else if (kind < 15) begin
        if (num > den) begin
          swap = num;
          num  = den;
          den  = swap;
        end
      end else if (kind < 22) begin
        den = num + $urandom_range(0, 2) - 1;
      end else if (kind < 30) begin
        num = random_wide();
        den = random_wide() | TOP_BIT;
      end else if (kind < 40) begin
        num = random_wide();
        den = random_wide() >> $urandom_range(HW - 8, DW - 1);
      end
      if (kind >= 5 && den == '0)
        den = 1;
      send_item(num, den, long_divide(num, den));
      maybe_idle(n >= RANDOM_ITEMS - QUIET_ITEMS);
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain: wait for every owed result, then one more divide time plus a margin
    // so that an unexpected extra strobe would still be caught.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DIVIDE_CYCLES + 10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // About 1025 items, each a full divide plus any idle gap, fit in a fraction
  // of this limit; the watchdog allows several times the expected run.
  initial begin : watchdog
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
